@@ sv/lpvi_pkg.sv @@
// Shared types and constants for the linear-probe versioned index.
// No dependencies; imported by lpvi_ctrl, lpvi_dp and linear_probe_versioned_index.
package lpvi_pkg;

	localparam int KEY_W = 64;
	localparam int SEG_W = 32;
	localparam int OFF_W = 48;
	localparam int VER_W = 64;
	localparam int CNT_W = 11;
	localparam int STS_W = 2;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [STS_W-1:0] STS_OK     = 2'd0;
	localparam logic [STS_W-1:0] STS_BADKEY = 2'd1;
	localparam logic [STS_W-1:0] STS_MISS   = 2'd2;
	localparam logic [STS_W-1:0] STS_FULL   = 2'd3;

	localparam logic [KEY_W-1:0] EMPTY_KEY = '0;

	// payload kept per slot besides the key
	typedef struct packed {
		logic [VER_W-1:0] ver;
		logic [OFF_W-1:0] off;
		logic [SEG_W-1:0] seg;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;    // write empty marker at clear pointer, step pointer
		logic load;     // capture input transaction, read home slot
		logic advance;  // move probe to next slot
		logic finish;   // commit writes and load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic zero_key;
		logic empty;
		logic hit;
		logic last_probe;
		logic clear_last;
		logic out_free;
	} stat_t;

endpackage

@@ sv/lpvi_ctrl.sv @@
// Sequencer for the linear-probe index: clearing pass, idle, probe loop.
// Depends on lpvi_pkg for the command and status structs.
module lpvi_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lpvi_pkg::stat_t stat,
	output lpvi_pkg::cmd_t  cmd
);
	import lpvi_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_PROBE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done;

	// the probe ends on a zero key, an empty slot, a match or a full wrap
	assign done = stat.zero_key | stat.empty | stat.hit | stat.last_probe;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (!done) begin
					cmd.advance = 1'b1;
				end else if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else         state_q <= state_d;
	end

endmodule

@@ sv/lpvi_dp.sv @@
// Datapath for the linear-probe index: key and entry memories, probe pointer,
// comparators, occupancy counter and result register. Depends on lpvi_pkg.
module lpvi_dp #(
	parameter int TABLE_SLOTS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lpvi_pkg::cmd_t              cmd,
	output lpvi_pkg::stat_t             stat,
	input  logic                        command,
	input  logic [lpvi_pkg::KEY_W-1:0]  key,
	input  logic [lpvi_pkg::SEG_W-1:0]  segment,
	input  logic [lpvi_pkg::OFF_W-1:0]  offset,
	input  logic [lpvi_pkg::VER_W-1:0]  version,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lpvi_pkg::STS_W-1:0]  status,
	output logic [lpvi_pkg::SEG_W-1:0]  found_segment,
	output logic [lpvi_pkg::OFF_W-1:0]  found_offset,
	output logic [lpvi_pkg::CNT_W-1:0]  entry_count
);
	import lpvi_pkg::*;

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);

	logic             cmd_q;
	logic [KEY_W-1:0] key_q;
	entry_t           new_q;

	logic [AW-1:0]    slot_q;
	logic [AW-1:0]    probe_q;
	logic [AW-1:0]    slot_inc;
	logic [AW-1:0]    rd_addr;

	logic [KEY_W-1:0] key_mem [TABLE_SLOTS];
	entry_t           ent_mem [TABLE_SLOTS];
	logic [KEY_W-1:0] key_rd_q;
	entry_t           ent_rd_q;

	logic             key_we;
	logic [KEY_W-1:0] key_wd;
	logic             ent_we;
	logic             claim;
	logic             update;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             out_valid_q;
	logic [STS_W-1:0] res_sts;
	logic             res_data;

	assign slot_inc = slot_q + 1'b1;

	// next slot is read ahead so its key is registered when the probe steps onto it
	always_comb begin
		if (cmd.load)         rd_addr = key[AW-1:0];
		else if (cmd.advance) rd_addr = slot_inc;
		else                  rd_addr = slot_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q     <= command;
			key_q     <= key;
			new_q.seg <= segment;
			new_q.off <= offset;
			new_q.ver <= version;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			probe_q <= '0;
		end else if (cmd.load) begin
			slot_q  <= key[AW-1:0];
			probe_q <= '0;
		end else if (cmd.clear || cmd.advance) begin
			slot_q  <= slot_inc;
			probe_q <= probe_q + 1'b1;
		end
	end

	assign stat.zero_key   = (key_q == EMPTY_KEY);
	assign stat.empty      = (key_rd_q == EMPTY_KEY);
	assign stat.hit        = (key_rd_q == key_q);
	assign stat.last_probe = (probe_q == LAST_SLOT);
	assign stat.clear_last = (slot_q == LAST_SLOT);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign claim  = !stat.zero_key && stat.empty && (cmd_q == CMD_INSERT);
	assign update = !stat.zero_key && !stat.empty && stat.hit && (cmd_q == CMD_INSERT)
		&& (new_q.ver >= ent_rd_q.ver);

	assign key_we = cmd.clear || (cmd.finish && claim);
	assign key_wd = cmd.clear ? EMPTY_KEY : key_q;
	assign ent_we = cmd.finish && (claim || update);

	always_ff @(posedge clk) begin
		if (key_we) key_mem[slot_q] <= key_wd;
		key_rd_q <= key_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[slot_q] <= new_q;
		ent_rd_q <= ent_mem[rd_addr];
	end

	always_comb begin
		res_data = 1'b0;
		if (stat.zero_key) begin
			res_sts = STS_BADKEY;
		end else if (stat.empty) begin
			res_sts = (cmd_q == CMD_INSERT) ? STS_OK : STS_MISS;
		end else if (stat.hit) begin
			res_sts  = STS_OK;
			res_data = (cmd_q == CMD_LOOKUP);
		end else begin
			// wrapped the whole table without a match or a hole
			res_sts = (cmd_q == CMD_INSERT) ? STS_FULL : STS_MISS;
		end
	end

	assign count_d = count_q + CNT_W'(claim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status        <= res_sts;
			found_segment <= res_data ? ent_rd_q.seg : '0;
			found_offset  <= res_data ? ent_rd_q.off : '0;
			entry_count   <= count_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/linear_probe_versioned_index.sv @@
// Top level of the linear-probe versioned hash index.
// Instantiates lpvi_ctrl and lpvi_dp; uses lpvi_pkg types.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------------
//  in      | input     | in_valid / in_ready   | command, key, segment, offset, version
//  out     | output    | out_valid / out_ready | status, found_segment, found_offset, entry_count
//
// An operation is accepted in the idle state and then probes slots in the probe state, paced by
// the registered read of the key memory with the next slot addressed ahead: P slots are probed
// (P from 1 to TABLE_SLOTS); a zero key finishes in the first probe state without advancing.
// After reset a clearing pass empties every slot of the key memory; in_ready is low meanwhile.
// A finished result waits in the probe state while the output register is still held.
// One operation is in flight at a time.
module linear_probe_versioned_index #(
	parameter int TABLE_SLOTS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        command,
	input  logic [lpvi_pkg::KEY_W-1:0]  key,
	input  logic [lpvi_pkg::SEG_W-1:0]  segment,
	input  logic [lpvi_pkg::OFF_W-1:0]  offset,
	input  logic [lpvi_pkg::VER_W-1:0]  version,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lpvi_pkg::STS_W-1:0]  status,
	output logic [lpvi_pkg::SEG_W-1:0]  found_segment,
	output logic [lpvi_pkg::OFF_W-1:0]  found_offset,
	output logic [lpvi_pkg::CNT_W-1:0]  entry_count
);
	import lpvi_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lpvi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lpvi_dp #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.command       (command),
		.key           (key),
		.segment       (segment),
		.offset        (offset),
		.version       (version),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.found_segment (found_segment),
		.found_offset  (found_offset),
		.entry_count   (entry_count)
	);

	// a result is committed only when the output register can take it
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid || out_ready))
		else $error("result committed over a pending output");

	// one operation in flight: no new transaction right after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while an operation is in flight");

	// clearing pass never overlaps a load, a commit or in_ready
	a_clear_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clear && (cmd.finish || cmd.load || in_ready)))
		else $error("operation during clearing pass");

	// output valid only comes from a committed operation
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.finish))
		else $error("output valid without a commit");

endmodule

@@ bench/tb_linear_probe_versioned_index.sv @@
// Self-checking bench for the linear-probe versioned hash index.
// Needs lpvi_pkg and linear_probe_versioned_index; keeps a shadow index and checks each reply.
module tb_linear_probe_versioned_index;
	timeunit 1ns;
	timeprecision 1ps;

	import lpvi_pkg::*;

	localparam int SLOTS       = 1024;
	localparam int SLOT_BITS   = $clog2(SLOTS);
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [STS_W-1:0] status;
		logic [SEG_W-1:0] seg;
		logic [OFF_W-1:0] off;
		logic [CNT_W-1:0] count;
	} index_reply_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic             command;
	logic [KEY_W-1:0] key;
	logic [SEG_W-1:0] segment;
	logic [OFF_W-1:0] offset;
	logic [VER_W-1:0] version;
	logic             out_valid;
	logic             out_ready;
	logic [STS_W-1:0] status;
	logic [SEG_W-1:0] found_segment;
	logic [OFF_W-1:0] found_offset;
	logic [CNT_W-1:0] entry_count;

	// shadow copy of the index
	logic [KEY_W-1:0] shadow_key [SLOTS];
	logic [SEG_W-1:0] shadow_seg [SLOTS];
	logic [OFF_W-1:0] shadow_off [SLOTS];
	logic [VER_W-1:0] shadow_ver [SLOTS];
	int               occupied;

	index_reply_t     index_replies[$];
	logic [KEY_W-1:0] known_keys[$];

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int rx_hold_left = 0;
	int mismatches   = 0;
	int cycle_count  = 0;

	linear_probe_versioned_index #(.TABLE_SLOTS(SLOTS)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.key          (key),
		.segment      (segment),
		.offset       (offset),
		.version      (version),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.found_segment(found_segment),
		.found_offset (found_offset),
		.entry_count  (entry_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("linear_probe_versioned_index test failed");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [OFF_W-1:0] rand_offset();
		logic [63:0] t;
		t = rand64();
		return t[OFF_W-1:0];
	endfunction

	// apply one operation to the shadow index and return the reply it gives
	function automatic index_reply_t shadow_index_op(input logic cmd, input logic [KEY_W-1:0] k,
			input logic [SEG_W-1:0] seg, input logic [OFF_W-1:0] off,
			input logic [VER_W-1:0] ver);
		index_reply_t r;
		int           slot;
		bit           done;
		r = '0;
		done = 1'b0;
		if (k == EMPTY_KEY) begin
			r.status = STS_BADKEY;
		end else begin
			r.status = (cmd == CMD_INSERT) ? STS_FULL : STS_MISS;
			slot = int'(k[SLOT_BITS-1:0]);
			for (int probe = 0; probe < SLOTS && !done; probe++) begin
				if (shadow_key[slot] == EMPTY_KEY) begin
					if (cmd == CMD_INSERT) begin
						shadow_key[slot] = k;
						shadow_seg[slot] = seg;
						shadow_off[slot] = off;
						shadow_ver[slot] = ver;
						occupied++;
						r.status = STS_OK;
					end else begin
						r.status = STS_MISS;
					end
					done = 1'b1;
				end else if (shadow_key[slot] == k) begin
					r.status = STS_OK;
					if (cmd == CMD_INSERT) begin
						if (ver >= shadow_ver[slot]) begin
							shadow_seg[slot] = seg;
							shadow_off[slot] = off;
							shadow_ver[slot] = ver;
						end
					end else begin
						r.seg = shadow_seg[slot];
						r.off = shadow_off[slot];
					end
					done = 1'b1;
				end else begin
					slot = (slot + 1) % SLOTS;
				end
			end
		end
		r.count = occupied[CNT_W-1:0];
		return r;
	endfunction

	// random nonzero key, often sharing a home slot with a known key or near the wrap
	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] other;
		k = rand64();
		case ($urandom_range(0, 3))
			0: begin
				if (known_keys.size() > 0) begin
					other = known_keys[$urandom_range(0, known_keys.size() - 1)];
					k[SLOT_BITS-1:0] = other[SLOT_BITS-1:0];
				end
			end
			1: begin
				k[SLOT_BITS-1:0] = SLOT_BITS'($urandom_range(SLOTS - 6, SLOTS + 5));
			end
			default: begin
			end
		endcase
		if (k == EMPTY_KEY)
			k[KEY_W-1] = 1'b1;
		return k;
	endfunction

	function automatic logic [KEY_W-1:0] known_key();
		if (known_keys.size() == 0)
			return fresh_key();
		return known_keys[$urandom_range(0, known_keys.size() - 1)];
	endfunction

	// version just below, at or above the stored one, or anything
	function automatic logic [VER_W-1:0] pick_version(input logic [KEY_W-1:0] k);
		int               slot;
		logic [VER_W-1:0] stored;
		stored = rand64();
		slot = int'(k[SLOT_BITS-1:0]);
		for (int p = 0; p < SLOTS; p++) begin
			if (shadow_key[slot] == k) begin
				stored = shadow_ver[slot];
				break;
			end
			if (shadow_key[slot] == EMPTY_KEY)
				break;
			slot = (slot + 1) % SLOTS;
		end
		case ($urandom_range(0, 3))
			0: return stored - 1;
			1: return stored;
			2: return stored + 1;
			default: return rand64();
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// starts and returns at a rising edge; valid stays up unless a gap follows
	task automatic send_op(input logic cmd, input logic [KEY_W-1:0] k,
			input logic [SEG_W-1:0] seg, input logic [OFF_W-1:0] off,
			input logic [VER_W-1:0] ver);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		command  = cmd;
		key      = k;
		segment  = seg;
		offset   = off;
		version  = ver;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		index_replies.push_back(shadow_index_op(cmd, k, seg, off, ver));
	endtask

	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			out_ready <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin : reply_check
		index_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (index_replies.size() == 0) begin
				report_mismatch("reply with no pending transaction", 64'(status), 64'd0);
			end else begin
				want = index_replies.pop_front();
				if (status !== want.status)
					report_mismatch("status", 64'(status), 64'(want.status));
				if (found_segment !== want.seg)
					report_mismatch("found_segment", 64'(found_segment), 64'(want.seg));
				if (found_offset !== want.off)
					report_mismatch("found_offset", 64'(found_offset), 64'(want.off));
				if (entry_count !== want.count)
					report_mismatch("entry_count", 64'(entry_count), 64'(want.count));
			end
		end
	end

	task automatic mix_items(input int n);
		int               pick;
		logic [KEY_W-1:0] k;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_op(($urandom_range(0, 1) == 0) ? CMD_INSERT : CMD_LOOKUP, EMPTY_KEY,
					$urandom, rand_offset(), rand64());
			end else if (pick < 30) begin
				k = fresh_key();
				known_keys.push_back(k);
				send_op(CMD_INSERT, k, $urandom, rand_offset(), rand64());
			end else if (pick < 55) begin
				k = known_key();
				send_op(CMD_INSERT, k, $urandom, rand_offset(), pick_version(k));
			end else if (pick < 85) begin
				send_op(CMD_LOOKUP, known_key(), $urandom, rand_offset(), rand64());
			end else begin
				send_op(CMD_LOOKUP, fresh_key(), $urandom, rand_offset(), rand64());
			end
		end
	endtask

	task automatic test_directed_cases();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		send_op(CMD_LOOKUP, 64'd1, '0, '0, '0);
		send_op(CMD_INSERT, EMPTY_KEY, '1, '1, '1);
		send_op(CMD_LOOKUP, EMPTY_KEY, '1, '1, '1);
		// last slot, then a colliding key wraps to slot 0, and a key homed at 0 moves to 1
		send_op(CMD_INSERT, '1, '1, '1, '1);
		send_op(CMD_LOOKUP, '1, '0, '0, '0);
		send_op(CMD_INSERT, 64'h8000_0000_0000_03FF, 32'h1234_5678, 48'hA5A5_5A5A_0F0F, 64'd7);
		send_op(CMD_INSERT, 64'h0000_0000_0000_0400, '0, '0, '0);
		send_op(CMD_LOOKUP, 64'h8000_0000_0000_03FF, '0, '0, '0);
		send_op(CMD_LOOKUP, 64'h0000_0000_0000_0400, '1, '1, '1);
		// older version is ignored, equal version overwrites
		send_op(CMD_INSERT, '1, 32'hDEAD_BEEF, 48'h1, 64'hFFFF_FFFF_FFFF_FFFE);
		send_op(CMD_LOOKUP, '1, '0, '0, '0);
		send_op(CMD_INSERT, '1, '0, '0, '1);
		send_op(CMD_LOOKUP, '1, '0, '0, '0);
		send_op(CMD_INSERT, 64'h0000_0000_0000_0400, 32'h5555_AAAA, 48'h8000_0000_0001, '0);
		send_op(CMD_LOOKUP, 64'h0000_0000_0000_0400, '0, '0, '0);
		// miss that walks the wrapped cluster
		send_op(CMD_LOOKUP, 64'h4000_0000_0000_03FF, '0, '0, '0);
		send_op(CMD_INSERT, 64'd1, 32'hAAAA_5555, 48'h7FFF_FFFF_FFFE, 64'h8000_0000_0000_0000);
		send_op(CMD_LOOKUP, 64'd1, '0, '0, '0);
		known_keys.push_back('1);
		known_keys.push_back(64'h8000_0000_0000_03FF);
		known_keys.push_back(64'h0000_0000_0000_0400);
		known_keys.push_back(64'd1);
	endtask

	task automatic test_mix_no_idle();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		mix_items(70);
	endtask

	task automatic test_mix_sender_idle();
		tx_idle_pct  = 55;
		rx_stall_pct = 0;
		mix_items(70);
	endtask

	task automatic test_mix_receiver_stall();
		tx_idle_pct  = 0;
		rx_stall_pct = 55;
		mix_items(70);
	endtask

	task automatic test_mix_both_idle();
		tx_idle_pct  = 8;
		rx_stall_pct = 8;
		mix_items(70);
	endtask

	// receiver holds off while the sender keeps offering, so in_ready must drop
	task automatic test_output_hold_off();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		rx_hold_left = 400;
		mix_items(12);
	endtask

	// fill every slot, then exercise inserts and lookups against a full table
	task automatic test_fill_to_capacity();
		int               pick;
		int               slot;
		logic [KEY_W-1:0] k;
		tx_idle_pct  = 8;
		rx_stall_pct = 8;
		while (occupied < SLOTS) begin
			pick = $urandom_range(0, 99);
			if (pick < 92) begin
				// aim the key at an empty home slot so each fill is a single probe
				slot = $urandom_range(0, SLOTS - 1);
				while (shadow_key[slot] != EMPTY_KEY)
					slot = (slot + 1) % SLOTS;
				k = rand64();
				k[SLOT_BITS-1:0] = SLOT_BITS'(slot);
				if (k == EMPTY_KEY)
					k[KEY_W-1] = 1'b1;
				known_keys.push_back(k);
				send_op(CMD_INSERT, k, $urandom, rand_offset(), rand64());
			end else if (pick < 96) begin
				send_op(CMD_LOOKUP, known_key(), $urandom, rand_offset(), rand64());
			end else begin
				k = known_key();
				send_op(CMD_INSERT, k, $urandom, rand_offset(), pick_version(k));
			end
		end
		for (int i = 0; i < 15; i++)
			send_op(CMD_INSERT, fresh_key(), $urandom, rand_offset(), rand64());
		for (int i = 0; i < 15; i++)
			send_op(CMD_LOOKUP, fresh_key(), $urandom, rand_offset(), rand64());
		for (int i = 0; i < 8; i++)
			send_op(CMD_LOOKUP, known_key(), $urandom, rand_offset(), rand64());
		for (int i = 0; i < 6; i++) begin
			k = known_key();
			send_op(CMD_INSERT, k, $urandom, rand_offset(), pick_version(k));
		end
		send_op(CMD_INSERT, EMPTY_KEY, $urandom, rand_offset(), rand64());
		send_op(CMD_LOOKUP, EMPTY_KEY, $urandom, rand_offset(), rand64());
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		command   = CMD_INSERT;
		key       = '0;
		segment   = '0;
		offset    = '0;
		version   = '0;
		out_ready = 1'b0;
		occupied  = 0;
		foreach (shadow_key[i]) begin
			shadow_key[i] = EMPTY_KEY;
			shadow_seg[i] = '0;
			shadow_off[i] = '0;
			shadow_ver[i] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_mix_no_idle();
		test_mix_sender_idle();
		test_mix_receiver_stall();
		test_mix_both_idle();
		test_output_hold_off();
		test_fill_to_capacity();

		@(negedge clk);
		in_valid = 1'b0;
		while (index_replies.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);
		if (mismatches == 0)
			$display("linear_probe_versioned_index test passed");
		else
			$display("linear_probe_versioned_index test failed");
		$finish;
	end

endmodule

@@ sim.f @@
sv/lpvi_pkg.sv
sv/lpvi_ctrl.sv
sv/lpvi_dp.sv
sv/linear_probe_versioned_index.sv
bench/tb_linear_probe_versioned_index.sv
